// ===== hdl/periodic_pair_distance_finder_defines.svh =====
// ---------------------------------------------------------------------------
// Periodic pair distance finder assertion macros
// Shared concurrent assertion forms for the pair finder.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_PAIR_DISTANCE_FINDER_DEFINES_SVH
`define PERIODIC_PAIR_DISTANCE_FINDER_DEFINES_SVH

// same-cycle implication
`define PPDF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PPDF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ppdf_pkg.sv =====
// ---------------------------------------------------------------------------
// Pair finder package
// Widths, register indexes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`default_nettype none
package ppdf_pkg;
   localparam int MAX_HALOS = 64;
   localparam int POS_W     = 28;
   localparam int ID_W      = 31;
   localparam int CNT_PW    = 31;
   localparam int ADDR_W    = $clog2(MAX_HALOS);
   localparam int CNT_W     = ADDR_W + 1;
   localparam int DIFF_W    = POS_W + 2;
   localparam int SQ_W      = 2 * POS_W;
   localparam int SUM_W     = SQ_W + 2;
   localparam int ROOT_W    = SUM_W / 2;
   localparam int DIST_W    = 29;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 31;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_LENGTH    = 3'd0,
      CSR_PERIODIC_EN   = 3'd1,
      CSR_LEN_MIN       = 3'd2,
      CSR_LEN_MAX       = 3'd3,
      CSR_MIN_PARTICLES = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic              load;
      logic              wr;
      logic [ADDR_W-1:0] wr_addr;
      logic              full;
      logic              rd_vld;
      logic [ADDR_W-1:0] rd_addr;
      logic              fin;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic adv;
      logic pipe_busy;
      logic out_free;
   } sts_type;
endpackage
`default_nettype wire

// ===== hdl/periodic_pair_distance_finder.sv =====
// ---------------------------------------------------------------------------
// Periodic pair distance finder
// Compares each non-skipped request halo with all stored halos, reports pairs in window.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | restart, halo_id, pos_x/y/z, count
//  rsp     | out       | rsp_valid/stall    | pair_found, ids, distance, full, last
//  csr     | in        | csr_valid/ready    | csr_index, csr_wdata
//
//  A request with n stored halos reads one store entry per cycle while the
//  output does not hold the pipeline, feeding a 3-stage wrap/square/sum path
//  and a 29-stage root pipeline. Skipped halos and an empty store skip the walk.
//  Reset: synchronous; store contents stay undefined, count clears.
//  rsp_stall holds the root pipeline once a second pair waits behind the output.
// ---------------------------------------------------------------------------
`default_nettype none
`include "periodic_pair_distance_finder_defines.svh"
module periodic_pair_distance_finder (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_restart,
   input  wire logic [ppdf_pkg::ID_W-1:0]      req_halo_id,
   input  wire logic [ppdf_pkg::POS_W-1:0]     req_pos_x,
   input  wire logic [ppdf_pkg::POS_W-1:0]     req_pos_y,
   input  wire logic [ppdf_pkg::POS_W-1:0]     req_pos_z,
   input  wire logic [ppdf_pkg::CNT_PW-1:0]    req_particle_count,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_pair_found,
   output logic [ppdf_pkg::ID_W-1:0]           rsp_id_earlier,
   output logic [ppdf_pkg::ID_W-1:0]           rsp_id_current,
   output logic [ppdf_pkg::DIST_W-1:0]         rsp_distance,
   output logic                                rsp_store_full,
   output logic                                rsp_last,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [ppdf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ppdf_pkg::CSR_DAT_W-1:0] csr_wdata
);
   ppdf_pkg::cmd_type cmd;
   ppdf_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   ppdf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   ppdf_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_valid          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_halo_id        (req_halo_id),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .req_particle_count (req_particle_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pair_found     (rsp_pair_found),
      .rsp_id_earlier     (rsp_id_earlier),
      .rsp_id_current     (rsp_id_current),
      .rsp_distance       (rsp_distance),
      .rsp_store_full     (rsp_store_full),
      .rsp_last           (rsp_last)
   );

   `PPDF_ASSERT_NOW(a_accept_idle_pipe, clock, reset, req_valid && !req_stall, !sts.pipe_busy, "request accepted with pipeline busy")
   `PPDF_ASSERT_NEXT(a_final_emits_last, clock, reset, cmd.fin && sts.out_free, rsp_valid && rsp_last, "final result not issued")
   `PPDF_ASSERT_NOW(a_nopair_zero, clock, reset, rsp_valid && !rsp_pair_found, rsp_last && rsp_distance == '0 && rsp_id_earlier == '0, "bad no-pair result")
endmodule
`default_nettype wire

// ===== hdl/ppdf_ctrl.sv =====
// ---------------------------------------------------------------------------
// Pair finder controller
// Accepts requests, keeps the store count and sequences the store walk.
// ---------------------------------------------------------------------------
`default_nettype none
module ppdf_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_restart,
   output logic                  req_stall,
   input  wire ppdf_pkg::sts_type sts,
   output ppdf_pkg::cmd_type     cmd
);
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_FINAL = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [ppdf_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [ppdf_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [ppdf_pkg::ADDR_W-1:0]   lastaddr_ff, lastaddr_in;
   logic [ppdf_pkg::CNT_W-1:0]    cnt_sel;
   logic                          accept, full;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign cnt_sel   = req_restart ? '0 : count_ff;
   assign full      = (cnt_sel == ppdf_pkg::CNT_W'(ppdf_pkg::MAX_HALOS));

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      addr_in     = addr_ff;
      lastaddr_in = lastaddr_ff;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load    = 1'b1;
               cmd.full    = full && !sts.skip;
               cmd.wr      = !full && !sts.skip;
               cmd.wr_addr = cnt_sel[ppdf_pkg::ADDR_W-1:0];
               addr_in     = '0;
               lastaddr_in = ppdf_pkg::ADDR_W'(cnt_sel - 1'b1);
               if (sts.skip || full) count_in = cnt_sel;
               else count_in = cnt_sel + 1'b1;
               if (sts.skip || cnt_sel == '0) state_in = ST_FINAL;
               else state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.rd_vld  = sts.adv;
            cmd.rd_addr = addr_ff;
            if (sts.adv) begin
               if (addr_ff == lastaddr_ff) state_in = ST_DRAIN;
               else addr_in = addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            cmd.fin = 1'b1;
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      lastaddr_ff <= lastaddr_in;
   end
endmodule
`default_nettype wire

// ===== hdl/ppdf_datapath.sv =====
// ---------------------------------------------------------------------------
// Pair finder datapath
// Halo store, wrap/square/sum stages, pipelined root, window and result regs.
// ---------------------------------------------------------------------------
`default_nettype none
module ppdf_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ppdf_pkg::cmd_type                cmd,
   output ppdf_pkg::sts_type                     sts,
   input  wire logic                             csr_valid,
   input  wire logic [ppdf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ppdf_pkg::CSR_DAT_W-1:0]   csr_wdata,
   input  wire logic [ppdf_pkg::ID_W-1:0]        req_halo_id,
   input  wire logic [ppdf_pkg::POS_W-1:0]       req_pos_x,
   input  wire logic [ppdf_pkg::POS_W-1:0]       req_pos_y,
   input  wire logic [ppdf_pkg::POS_W-1:0]       req_pos_z,
   input  wire logic [ppdf_pkg::CNT_PW-1:0]      req_particle_count,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_pair_found,
   output logic [ppdf_pkg::ID_W-1:0]             rsp_id_earlier,
   output logic [ppdf_pkg::ID_W-1:0]             rsp_id_current,
   output logic [ppdf_pkg::DIST_W-1:0]           rsp_distance,
   output logic                                  rsp_store_full,
   output logic                                  rsp_last
);
   localparam int POS_W  = ppdf_pkg::POS_W;
   localparam int ID_W   = ppdf_pkg::ID_W;
   localparam int DIFF_W = ppdf_pkg::DIFF_W;
   localparam int SQ_W   = ppdf_pkg::SQ_W;
   localparam int SUM_W  = ppdf_pkg::SUM_W;
   localparam int ROOT_W = ppdf_pkg::ROOT_W;
   localparam int DIST_W = ppdf_pkg::DIST_W;
   localparam logic [SUM_W:0] ONE = 1;

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [POS_W-1:0] z;
      logic [ID_W-1:0]  id;
   } entry_type;

   // configuration
   logic [POS_W-1:0]           box_ff;
   logic                       per_ff;
   logic [DIST_W-1:0]          lmin_ff, lmax_ff;
   logic [ppdf_pkg::CNT_PW-1:0] minp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff  <= '1;
         per_ff  <= 1'b1;
         lmin_ff <= '0;
         lmax_ff <= '1;
         minp_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            ppdf_pkg::CSR_BOX_LENGTH:    box_ff  <= csr_wdata[POS_W-1:0];
            ppdf_pkg::CSR_PERIODIC_EN:   per_ff  <= csr_wdata[0];
            ppdf_pkg::CSR_LEN_MIN:       lmin_ff <= csr_wdata[DIST_W-1:0];
            ppdf_pkg::CSR_LEN_MAX:       lmax_ff <= csr_wdata[DIST_W-1:0];
            ppdf_pkg::CSR_MIN_PARTICLES: minp_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign sts.skip = (minp_ff != '0) && (req_particle_count < minp_ff);

   // current request
   logic [ID_W-1:0]  cur_id_ff;
   logic [POS_W-1:0] cur_x_ff, cur_y_ff, cur_z_ff;
   logic             cur_full_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_id_ff   <= req_halo_id;
         cur_x_ff    <= req_pos_x;
         cur_y_ff    <= req_pos_y;
         cur_z_ff    <= req_pos_z;
         cur_full_ff <= cmd.full;
      end
   end

   // halo store
   entry_type mem [ppdf_pkg::MAX_HALOS];
   entry_type rd_ff;
   logic      adv;

   always_ff @(posedge clock) begin
      if (cmd.wr) mem[cmd.wr_addr] <= '{req_pos_x, req_pos_y, req_pos_z, req_halo_id};
      if (adv) rd_ff <= mem[cmd.rd_addr];
   end

   function automatic logic [POS_W-1:0] axis_mag(
      input logic [POS_W-1:0] a,
      input logic [POS_W-1:0] b,
      input logic [POS_W-1:0] box,
      input logic             en
   );
      logic signed [DIFF_W-1:0] d, half, bx;
      d    = signed'(DIFF_W'(a)) - signed'(DIFF_W'(b));
      half = signed'(DIFF_W'(box >> 1));
      bx   = signed'(DIFF_W'(box));
      if (en) begin
         if (d > half) d = d - bx;
         else if (d < -half) d = d + bx;
      end
      if (d < 0) d = -d;
      return d[POS_W-1:0];
   endfunction

   // wrap, square, sum
   logic                 rd_vld_ff, b_vld_ff, c_vld_ff;
   logic [POS_W-1:0]     mx_ff, my_ff, mz_ff;
   logic [ID_W-1:0]      b_id_ff, c_id_ff;
   logic [SQ_W-1:0]      sx_ff, sy_ff, sz_ff;

   // root stages: index 0 holds the sum
   logic [SUM_W-1:0]     rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0]    root_ff [ROOT_W+1];
   logic [ID_W-1:0]      sid_ff  [ROOT_W+1];
   logic [ROOT_W:0]      svld_ff;
   logic [SUM_W-1:0]     rem_in  [ROOT_W+1];
   logic [ROOT_W-1:0]    root_in [ROOT_W+1];

   always_comb begin
      int i;
      logic [SUM_W:0] trial;
      logic           take;
      rem_in[0]  = rem_ff[0];
      root_in[0] = root_ff[0];
      for (int k = 0; k < ROOT_W; k++) begin
         i     = ROOT_W - 1 - k;
         trial = ((SUM_W+1)'(root_ff[k]) << (i + 1)) + (ONE << (2 * i));
         take  = ({1'b0, rem_ff[k]} >= trial);
         rem_in[k+1]  = take ? rem_ff[k] - trial[SUM_W-1:0] : rem_ff[k];
         root_in[k+1] = root_ff[k] | (ROOT_W'(take) << i);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff      <= axis_mag(rd_ff.x, cur_x_ff, box_ff, per_ff);
         my_ff      <= axis_mag(rd_ff.y, cur_y_ff, box_ff, per_ff);
         mz_ff      <= axis_mag(rd_ff.z, cur_z_ff, box_ff, per_ff);
         b_id_ff    <= rd_ff.id;
         sx_ff      <= mx_ff * mx_ff;
         sy_ff      <= my_ff * my_ff;
         sz_ff      <= mz_ff * mz_ff;
         c_id_ff    <= b_id_ff;
         rem_ff[0]  <= SUM_W'(sx_ff) + SUM_W'(sy_ff) + SUM_W'(sz_ff);
         root_ff[0] <= '0;
         sid_ff[0]  <= c_id_ff;
         for (int k = 1; k <= ROOT_W; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            sid_ff[k]  <= sid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         b_vld_ff  <= 1'b0;
         c_vld_ff  <= 1'b0;
         svld_ff   <= '0;
      end else if (adv) begin
         rd_vld_ff <= cmd.rd_vld;
         b_vld_ff  <= rd_vld_ff;
         c_vld_ff  <= b_vld_ff;
         svld_ff   <= {svld_ff[ROOT_W-1:0], c_vld_ff};
      end
   end

   // window and result registers
   logic              tail_hit, out_free;
   logic [DIST_W-1:0] tail_dist;
   logic              pend_vld_ff;
   logic [ID_W-1:0]   pend_id_ff;
   logic [DIST_W-1:0] pend_dist_ff;

   assign tail_dist = DIST_W'(root_ff[ROOT_W]);
   assign tail_hit  = svld_ff[ROOT_W] && (tail_dist >= lmin_ff) && (tail_dist <= lmax_ff);
   assign out_free  = !rsp_valid || !rsp_stall;
   assign adv       = !(tail_hit && pend_vld_ff && !out_free);

   assign sts.adv       = adv;
   assign sts.out_free  = out_free;
   assign sts.pipe_busy = rd_vld_ff || b_vld_ff || c_vld_ff || (|svld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid   <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         if (out_free) rsp_valid <= 1'b0;
         if (tail_hit && adv) begin
            if (pend_vld_ff) begin
               rsp_valid      <= 1'b1;
               rsp_pair_found <= 1'b1;
               rsp_id_earlier <= pend_id_ff;
               rsp_id_current <= cur_id_ff;
               rsp_distance   <= pend_dist_ff;
               rsp_store_full <= cur_full_ff;
               rsp_last       <= 1'b0;
            end
            pend_vld_ff  <= 1'b1;
            pend_id_ff   <= sid_ff[ROOT_W];
            pend_dist_ff <= tail_dist;
         end
         if (cmd.fin && out_free) begin
            rsp_valid      <= 1'b1;
            rsp_pair_found <= pend_vld_ff;
            rsp_id_earlier <= pend_vld_ff ? pend_id_ff : '0;
            rsp_id_current <= cur_id_ff;
            rsp_distance   <= pend_vld_ff ? pend_dist_ff : '0;
            rsp_store_full <= cur_full_ff;
            rsp_last       <= 1'b1;
            pend_vld_ff    <= 1'b0;
         end
      end
   end
endmodule
`default_nettype wire

// ===== dv/periodic_pair_distance_finder_tb.sv =====
// ---------------------------------------------------------------------------
// Periodic pair distance finder testbench
// Drives halo requests and register writes, predicts each pair result with a
// local minimum-image distance model or a typed row expectation; checks in order.
// ---------------------------------------------------------------------------
`default_nettype none
module periodic_pair_distance_finder_tb;
   localparam int POS_W     = ppdf_pkg::POS_W;
   localparam int ID_W      = ppdf_pkg::ID_W;
   localparam int DIST_W    = ppdf_pkg::DIST_W;
   localparam int CNT_PW    = ppdf_pkg::CNT_PW;
   localparam int CSR_DAT_W = ppdf_pkg::CSR_DAT_W;
   localparam int CSR_IDX_W = ppdf_pkg::CSR_IDX_W;
   localparam int MAX_HALOS = ppdf_pkg::MAX_HALOS;

   localparam logic [POS_W-1:0]  POS_MAX  = '1;
   localparam logic [ID_W-1:0]   ID_MAX   = '1;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam int LIMIT_CYCLES = 1000000;

   typedef struct packed {
      logic              found;
      logic [ID_W-1:0]   early;
      logic [ID_W-1:0]   cur;
      logic [DIST_W-1:0] pair_len;
      logic              full;
      logic              last;
   } pair_res_type;

   typedef struct packed {
      logic              restart;
      logic [ID_W-1:0]   id;
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [POS_W-1:0]  z;
      logic [CNT_PW-1:0] np;
   } halo_type;

   typedef enum logic {ROW_HALO, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      ppdf_pkg::csr_index_type   idx;
      logic [CSR_DAT_W-1:0]      data;
      halo_type                  h;
      logic                      has_exp;
      pair_res_type              exp;
   } dir_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_stall;
   logic req_restart = 0;
   logic [ID_W-1:0] req_halo_id = '0;
   logic [POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [CNT_PW-1:0] req_particle_count = '0;
   logic rsp_valid, rsp_stall = 0;
   logic rsp_pair_found, rsp_store_full, rsp_last;
   logic [ID_W-1:0] rsp_id_earlier, rsp_id_current;
   logic [DIST_W-1:0] rsp_distance;
   logic csr_valid = 0, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // typed expectation travels with the request payload
   logic typed_on = 0;
   pair_res_type typed_res = '0;

   // predictor state
   logic [POS_W-1:0]  m_box;
   logic              m_periodic;
   logic [DIST_W-1:0] m_len_min, m_len_max;
   logic [CNT_PW-1:0] m_min_np;
   logic [POS_W-1:0]  m_x [MAX_HALOS];
   logic [POS_W-1:0]  m_y [MAX_HALOS];
   logic [POS_W-1:0]  m_z [MAX_HALOS];
   logic [ID_W-1:0]   m_id [MAX_HALOS];
   int                m_count;

   pair_res_type pending_pairs[$];
   bit failed = 0;
   int cycles = 0;
   int req_idle_pct = 9, rsp_idle_pct = 72;
   bit pressure_req = 0;
   int hold_left = 0;

   periodic_pair_distance_finder dut (.*);

   always #4 clock = ~clock;

   function automatic longint unsigned axis_sq(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
      longint d, half;
      d = longint'({36'd0, a}) - longint'({36'd0, b});
      if (m_periodic) begin
         half = longint'({36'd0, m_box >> 1});
         if (d > half) d -= longint'({36'd0, m_box});
         else if (d < -half) d += longint'({36'd0, m_box});
      end
      if (d < 0) d = -d;
      return longint'(d * d);
   endfunction

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic void predict_pairs(halo_type h, bit has_t, pair_res_type t);
      pair_res_type r;
      longint unsigned d;
      bit full;
      int n = 0;
      if (h.restart) m_count = 0;
      if (m_min_np != 0 && h.np < m_min_np) begin
         r = '{found: 0, early: 0, cur: h.id, pair_len: 0, full: 0, last: 1};
         pending_pairs.push_back(has_t ? t : r);
         return;
      end
      full = (m_count >= MAX_HALOS);
      for (int i = 0; i < m_count; i++) begin
         d = int_root(axis_sq(m_x[i], h.x) + axis_sq(m_y[i], h.y) + axis_sq(m_z[i], h.z));
         if (d >= m_len_min && d <= m_len_max) begin
            r = '{found: 1, early: m_id[i], cur: h.id, pair_len: d[DIST_W-1:0], full: full,
                  last: 0};
            if (has_t) r = t;
            pending_pairs.push_back(r);
            n++;
         end
      end
      if (!full) begin
         m_x[m_count] = h.x;
         m_y[m_count] = h.y;
         m_z[m_count] = h.z;
         m_id[m_count] = h.id;
         m_count++;
      end
      if (n == 0) begin
         r = '{found: 0, early: 0, cur: h.id, pair_len: 0, full: full, last: 0};
         pending_pairs.push_back(has_t ? t : r);
      end
      pending_pairs[$].last = 1;
   endfunction

   // monitor
   always @(posedge clock) begin
      pair_res_type got, want;
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end else if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ppdf_pkg::CSR_BOX_LENGTH:    m_box = csr_wdata[POS_W-1:0];
               ppdf_pkg::CSR_PERIODIC_EN:   m_periodic = csr_wdata[0];
               ppdf_pkg::CSR_LEN_MIN:       m_len_min = csr_wdata[DIST_W-1:0];
               ppdf_pkg::CSR_LEN_MAX:       m_len_max = csr_wdata[DIST_W-1:0];
               ppdf_pkg::CSR_MIN_PARTICLES: m_min_np = csr_wdata[CNT_PW-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_pairs('{req_restart, req_halo_id, req_pos_x, req_pos_y, req_pos_z,
                            req_particle_count}, typed_on, typed_res);
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_pair_found, rsp_id_earlier, rsp_id_current, rsp_distance,
                    rsp_store_full, rsp_last};
            if (pending_pairs.size() == 0) begin
               failed = 1;
               $display("%0t: unexpected result %p", $time, got);
            end else begin
               want = pending_pairs.pop_front();
               if (got != want) begin
                  failed = 1;
                  $display("%0t: mismatch expected %p actual %p", $time, want, got);
               end
            end
         end
      end
   end

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (pressure_req) begin
         hold_left = 600;
         pressure_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   task automatic offer_halo(halo_type h, bit has_t, pair_res_type t);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      {req_restart, req_halo_id, req_pos_x, req_pos_y, req_pos_z, req_particle_count} <= h;
      typed_on <= has_t;
      typed_res <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(ppdf_pkg::csr_index_type idx, logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [POS_W-1:0] rand_pos(int unsigned span);
      if ($urandom_range(7) == 0) return POS_W'($urandom);
      return POS_W'($urandom_range(span));
   endfunction

   dir_row_type dir_tab[] = '{
      '{ROW_HALO, ppdf_pkg::CSR_BOX_LENGTH, 0, '{0, 5, 0, 0, 0, 0}, 1, '{0, 0, 5, 0, 0, 1}},
      '{ROW_HALO, ppdf_pkg::CSR_BOX_LENGTH, 0,
        '{0, ID_MAX, POS_MAX, POS_MAX, POS_MAX, ID_MAX}, 1, '{1, 5, ID_MAX, 0, 0, 1}},
      '{ROW_HALO, ppdf_pkg::CSR_BOX_LENGTH, 0, '{0, 7, 256, 0, 0, 1}, 0, '0},
      '{ROW_HALO, ppdf_pkg::CSR_BOX_LENGTH, 0, '{0, 3, POS_MAX, 5, 1, 7}, 0, '0},
      '{ROW_REG, ppdf_pkg::CSR_MIN_PARTICLES, 100, '0, 0, '0},
      '{ROW_HALO, ppdf_pkg::CSR_BOX_LENGTH, 0, '{0, 9, 40, 40, 40, 99}, 1,
        '{0, 0, 9, 0, 0, 1}},
      '{ROW_HALO, ppdf_pkg::CSR_BOX_LENGTH, 0, '{0, 10, 40, 40, 40, 100}, 0, '0},
      '{ROW_REG, ppdf_pkg::CSR_PERIODIC_EN, 0, '0, 0, '0},
      '{ROW_REG, ppdf_pkg::CSR_BOX_LENGTH, 1000, '0, 0, '0},
      '{ROW_REG, ppdf_pkg::CSR_LEN_MIN, 300, '0, 0, '0},
      '{ROW_REG, ppdf_pkg::CSR_LEN_MAX, 2000, '0, 0, '0},
      '{ROW_HALO, ppdf_pkg::CSR_BOX_LENGTH, 0, '{1, 11, 0, 0, 0, 500}, 1,
        '{0, 0, 11, 0, 0, 1}},
      '{ROW_HALO, ppdf_pkg::CSR_BOX_LENGTH, 0, '{0, 12, 500, 0, 0, 500}, 0, '0},
      '{ROW_HALO, ppdf_pkg::CSR_BOX_LENGTH, 0, '{0, 13, 100, 0, 0, 500}, 0, '0},
      '{ROW_REG, ppdf_pkg::CSR_PERIODIC_EN, 1, '0, 0, '0},
      '{ROW_HALO, ppdf_pkg::CSR_BOX_LENGTH, 0, '{0, 14, 900, 0, 0, 500}, 0, '0},
      '{ROW_REG, ppdf_pkg::CSR_BOX_LENGTH, 1, '0, 0, '0},
      '{ROW_HALO, ppdf_pkg::CSR_BOX_LENGTH, 0, '{0, 15, 1, 1, 1, 500}, 0, '0},
      '{ROW_REG, ppdf_pkg::CSR_LEN_MIN, 0, '0, 0, '0},
      '{ROW_REG, ppdf_pkg::CSR_LEN_MAX, 0, '0, 0, '0},
      '{ROW_HALO, ppdf_pkg::CSR_BOX_LENGTH, 0, '{0, 16, 500, 0, 0, 500}, 0, '0},
      '{ROW_REG, ppdf_pkg::CSR_BOX_LENGTH, CSR_DAT_W'(POS_MAX), '0, 0, '0},
      '{ROW_REG, ppdf_pkg::CSR_LEN_MAX, CSR_DAT_W'(DIST_MAX), '0, 0, '0},
      '{ROW_REG, ppdf_pkg::CSR_MIN_PARTICLES, ID_MAX, '0, 0, '0},
      '{ROW_HALO, ppdf_pkg::CSR_BOX_LENGTH, 0, '{0, 17, 3, 3, 3, ID_W'(ID_MAX - 1)}, 1,
        '{0, 0, 17, 0, 0, 1}},
      '{ROW_HALO, ppdf_pkg::CSR_BOX_LENGTH, 0, '{0, 18, POS_MAX, 0, POS_MAX, ID_MAX},
        0, '0}
   };

   initial begin
      halo_type h;
      int unsigned span;
      m_box = POS_MAX;
      m_periodic = 1;
      m_len_min = 0;
      m_len_max = DIST_MAX;
      m_min_np = 0;
      m_count = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_REG) begin
            wait_drained();
            write_reg(dir_tab[i].idx, dir_tab[i].data);
         end else begin
            offer_halo(dir_tab[i].h, dir_tab[i].has_exp, dir_tab[i].exp);
         end
      end

      for (int p = 0; p < 3; p++) begin
         wait_drained();
         case (p)
            0: begin
               req_idle_pct = 9;
               rsp_idle_pct = 72;
               span = $urandom_range(1 << 16, 1 << 20);
               write_reg(ppdf_pkg::CSR_BOX_LENGTH, CSR_DAT_W'(span));
               write_reg(ppdf_pkg::CSR_PERIODIC_EN, 1);
               write_reg(ppdf_pkg::CSR_LEN_MIN, 0);
               write_reg(ppdf_pkg::CSR_LEN_MAX, CSR_DAT_W'($urandom_range(span / 4, span)));
               write_reg(ppdf_pkg::CSR_MIN_PARTICLES, 1000);
               pressure_req = 1;
            end
            1: begin
               req_idle_pct = 72;
               rsp_idle_pct = 9;
               span = 1 << 12;
               write_reg(ppdf_pkg::CSR_PERIODIC_EN, 0);
               write_reg(ppdf_pkg::CSR_BOX_LENGTH, 1);
               write_reg(ppdf_pkg::CSR_LEN_MIN, CSR_DAT_W'($urandom_range(0, 1000)));
               write_reg(ppdf_pkg::CSR_LEN_MAX, CSR_DAT_W'(DIST_MAX));
               write_reg(ppdf_pkg::CSR_MIN_PARTICLES, 0);
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
               span = 1 << 24;
               write_reg(ppdf_pkg::CSR_PERIODIC_EN, 1);
               write_reg(ppdf_pkg::CSR_BOX_LENGTH, CSR_DAT_W'(POS_MAX));
               write_reg(ppdf_pkg::CSR_LEN_MIN, CSR_DAT_W'($urandom_range(0, 1 << 22)));
               write_reg(ppdf_pkg::CSR_LEN_MAX,
                         CSR_DAT_W'($urandom_range(1 << 22, 1 << 24)));
            end
         endcase
         for (int n = 0; n < 60; n++) begin
            h.restart = ($urandom_range(49) == 0);
            h.id = ID_W'($urandom);
            h.x = rand_pos(span);
            h.y = rand_pos(span);
            h.z = rand_pos(span);
            h.np = ($urandom_range(9) == 0) ? CNT_PW'($urandom_range(0, 2000))
                                           : CNT_PW'($urandom);
            offer_halo(h, 0, '0);
         end
      end

      req_valid <= 0;
      @(posedge clock);
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (!failed && pending_pairs.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/ppdf_pkg.sv
hdl/ppdf_ctrl.sv
hdl/ppdf_datapath.sv
hdl/periodic_pair_distance_finder.sv
dv/periodic_pair_distance_finder_tb.sv
